// ===== hdl/scf_pkg.sv =====
`default_nettype none
package scf_pkg;

  localparam int unsigned NumSqrtStages = 16;
  localparam int unsigned NumDivStages  = 8;

  typedef enum logic [2:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_CENTER_Z     = 3'd2,
    REG_RADIUS       = 3'd3,
    REG_SPRING_GAIN  = 3'd4,
    REG_DAMP_LINEAR  = 3'd5,
    REG_DAMP_ANGULAR = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [2:0][31:0] center;
    logic [30:0]      radius;
    logic [30:0]      spring_gain;
    logic [30:0]      damp_linear;
    logic [30:0]      damp_angular;
  } cfg_t;

  typedef struct packed {
    logic             inr;
    logic             contact;
    logic [2:0]       neg;
    logic [4:0]       vneg;
    logic [2:0][32:0] am;
    logic [4:0][31:0] vmag;
    logic [2:0][61:0] sq;
    logic [61:0]      rsq;
    logic [4:0][62:0] dprod;
    logic [63:0]      x;
    logic [32:0]      srem;
    logic [31:0]      root;
    logic [61:0]      mprod;
    logic [2:0][31:0] drem;
    logic [2:0][16:0] quo;
  } item_t;

endpackage
`default_nettype wire

// ===== hdl/scf_front.sv =====
`default_nettype none
module scf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  scf_pkg::cfg_t cfg_i,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [255:0]  data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output scf_pkg::item_t item_o
);

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  scf_pkg::item_t it1_d, it1_q, it2_d, it2_q, it3_d, it3_q;

  assign en3     = !v3_q || ready_i;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  // offsets, magnitudes, range test
  always_comb begin
    logic [33:0] d;
    logic [33:0] dn;
    logic [31:0] v;
    logic [32:0] rad;
    it1_d = '0;
    rad   = {2'b00, cfg_i.radius};
    for (int i = 0; i < 3; i++) begin
      d  = {{2{data_i[32*i+31]}}, data_i[32*i +: 32]}
         - {{2{cfg_i.center[i][31]}}, cfg_i.center[i]};
      dn = 34'd0 - d;
      it1_d.neg[i] = d[33];
      it1_d.am[i]  = d[33] ? dn[32:0] : d[32:0];
    end
    for (int j = 0; j < 5; j++) begin
      v = data_i[32*(j+3) +: 32];
      it1_d.vneg[j] = v[31];
      it1_d.vmag[j] = v[31] ? (32'd0 - v) : v;
    end
    it1_d.inr = (it1_d.am[0] < rad) && (it1_d.am[1] < rad) && (it1_d.am[2] < rad);
  end

  // squares and damping products
  always_comb begin
    logic [30:0] g;
    it2_d = it1_q;
    for (int i = 0; i < 3; i++) begin
      it2_d.sq[i] = it1_q.am[i][30:0] * it1_q.am[i][30:0];
    end
    it2_d.rsq = cfg_i.radius * cfg_i.radius;
    for (int j = 0; j < 5; j++) begin
      g = (j < 3) ? cfg_i.damp_linear : cfg_i.damp_angular;
      it2_d.dprod[j] = {31'd0, it1_q.vmag[j]} * {32'd0, g};
    end
  end

  // squared length and contact
  always_comb begin
    logic [63:0] sum;
    it3_d = it2_q;
    sum = {2'b00, it2_q.sq[0]} + {2'b00, it2_q.sq[1]} + {2'b00, it2_q.sq[2]};
    it3_d.contact = it2_q.inr && (sum < {2'b00, it2_q.rsq});
    it3_d.x    = sum;
    it3_d.srem = '0;
    it3_d.root = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) it1_q <= it1_d;
    if (en2 && v1_q) it2_q <= it2_d;
    if (en3 && v2_q) it3_q <= it3_d;
  end

  assign valid_o = v3_q;
  assign item_o  = it3_q;

endmodule
`default_nettype wire

// ===== hdl/scf_sqrt_stage.sv =====
`default_nettype none
module scf_sqrt_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  scf_pkg::item_t item_i,
  output logic           valid_o,
  input  logic           ready_i,
  output scf_pkg::item_t item_o
);

  logic v_q;
  scf_pkg::item_t it_d, it_q;

  assign ready_o = !v_q || ready_i;

  // two root bits per stage
  always_comb begin
    logic [34:0] r2;
    logic [34:0] t;
    it_d = item_i;
    for (int s = 0; s < 2; s++) begin
      r2 = {it_d.srem, it_d.x[63:62]};
      t  = {1'b0, it_d.root, 2'b01};
      if (r2 >= t) begin
        r2 = r2 - t;
        it_d.srem = r2[32:0];
        it_d.root = {it_d.root[30:0], 1'b1};
      end else begin
        it_d.srem = r2[32:0];
        it_d.root = {it_d.root[30:0], 1'b0};
      end
      it_d.x = {it_d.x[61:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) it_q <= it_d;
  end

  assign valid_o = v_q;
  assign item_o  = it_q;

endmodule
`default_nettype wire

// ===== hdl/scf_prep.sv =====
`default_nettype none
module scf_prep (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  scf_pkg::cfg_t  cfg_i,
  input  logic           valid_i,
  output logic           ready_o,
  input  scf_pkg::item_t item_i,
  output logic           valid_o,
  input  logic           ready_i,
  output scf_pkg::item_t item_o
);

  logic v_q;
  scf_pkg::item_t it_d, it_q;

  assign ready_o = !v_q || ready_i;

  // penetration, spring magnitude product, first quotient bit
  always_comb begin
    logic [30:0] pen;
    it_d = item_i;
    pen  = cfg_i.radius - item_i.root[30:0];
    it_d.mprod = cfg_i.spring_gain * pen;
    for (int i = 0; i < 3; i++) begin
      if (item_i.am[i][31:0] >= item_i.root) begin
        it_d.drem[i] = item_i.am[i][31:0] - item_i.root;
        it_d.quo[i]  = 17'd1;
      end else begin
        it_d.drem[i] = item_i.am[i][31:0];
        it_d.quo[i]  = 17'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) it_q <= it_d;
  end

  assign valid_o = v_q;
  assign item_o  = it_q;

endmodule
`default_nettype wire

// ===== hdl/scf_div_stage.sv =====
`default_nettype none
module scf_div_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  scf_pkg::item_t item_i,
  output logic           valid_o,
  input  logic           ready_i,
  output scf_pkg::item_t item_o
);

  logic v_q;
  scf_pkg::item_t it_d, it_q;

  assign ready_o = !v_q || ready_i;

  // two quotient bits per stage on all three axes
  always_comb begin
    logic [31:0] r;
    it_d = item_i;
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < 3; i++) begin
        r = {it_d.drem[i][30:0], 1'b0};
        if (r >= it_d.root) begin
          it_d.drem[i] = r - it_d.root;
          it_d.quo[i]  = {it_d.quo[i][15:0], 1'b1};
        end else begin
          it_d.drem[i] = r;
          it_d.quo[i]  = {it_d.quo[i][15:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) it_q <= it_d;
  end

  assign valid_o = v_q;
  assign item_o  = it_q;

endmodule
`default_nettype wire

// ===== hdl/scf_back.sv =====
`default_nettype none
module scf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  scf_pkg::item_t item_i,
  output logic           valid_o,
  input  logic           ready_i,
  output logic [159:0]   data_o,
  output logic [1:0]     user_o
);

  logic v1_q, v2_q, en1, en2;
  scf_pkg::item_t it1_q;
  logic [2:0][62:0] fm_d, fm_q;
  logic [159:0] data_d, data_q;
  logic [1:0] user_d, user_q;

  assign en2     = !v2_q || ready_i;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fm_d[i] = {46'd0, item_i.quo[i]} * {17'd0, item_i.mprod[61:16]};
    end
  end

  // signed difference of spring and damping terms, saturation, zero outside contact
  always_comb begin
    logic [48:0] sp, dm, diff;
    logic clip;
    data_d = '0;
    clip   = 1'b0;
    for (int k = 0; k < 5; k++) begin
      dm = {2'b00, it1_q.dprod[k][62:16]};
      if (it1_q.vneg[k]) dm = 49'd0 - dm;
      sp = '0;
      if (k < 3 && it1_q.root != 32'd0) begin
        sp = {2'b00, fm_q[k%3][62:16]};
        if (it1_q.neg[k%3]) sp = 49'd0 - sp;
      end
      diff = sp - dm;
      if (diff[48:31] == '0 || diff[48:31] == '1) begin
        data_d[32*k +: 32] = diff[31:0];
      end else begin
        clip = 1'b1;
        data_d[32*k +: 32] = diff[48] ? 32'h8000_0000 : 32'h7fff_ffff;
      end
    end
    if (!it1_q.contact) begin
      data_d = '0;
      clip   = 1'b0;
    end
    user_d = {clip, it1_q.contact};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      it1_q <= item_i;
      fm_q  <= fm_d;
    end
    if (en2 && v1_q) begin
      data_q <= data_d;
      user_q <= user_d;
    end
  end

  assign valid_o = v2_q;
  assign data_o  = data_q;
  assign user_o  = user_q;

endmodule
`default_nettype wire

// ===== hdl/sphere_contact_force_core.sv =====
// channel   dir  fields (lowest bits first)
// s_axis    in   tdata: pos_x pos_y pos_z vel_x vel_y vel_z rate_roll rate_pitch
// m_axis    out  tdata: force_x force_y force_z torque_roll torque_pitch
//                tuser: in_contact clipped
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i, no read-back
//
// one beat per cycle sustained while m_axis accepts, through a chain of
// 3 front stages, 16 square-root stages (two root bits each), one setup
// stage, 8 divider stages (two quotient bits each) and 2 output stages.
// each stage holds on its own, so bubbles fill in while m_axis stalls.
// reset is asynchronous active low and loads the default registers.
`default_nettype none
module sphere_contact_force_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [255:0] s_axis_tdata,  // pos_x pos_y pos_z vel_x vel_y vel_z rate_roll rate_pitch
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [159:0] m_axis_tdata,  // force_x force_y force_z torque_roll torque_pitch
  output logic [1:0]   m_axis_tuser,  // in_contact clipped
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  scf_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center       <= {32'd0, 32'd19661, 32'd0};
      cfg_q.radius       <= 31'd3277;
      cfg_q.spring_gain  <= 31'd32768000;
      cfg_q.damp_linear  <= 31'd327680;
      cfg_q.damp_angular <= 31'd6554;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        scf_pkg::REG_CENTER_X:     cfg_q.center[0]    <= cfg_data_i;
        scf_pkg::REG_CENTER_Y:     cfg_q.center[1]    <= cfg_data_i;
        scf_pkg::REG_CENTER_Z:     cfg_q.center[2]    <= cfg_data_i;
        scf_pkg::REG_RADIUS:       cfg_q.radius       <= cfg_data_i[30:0];
        scf_pkg::REG_SPRING_GAIN:  cfg_q.spring_gain  <= cfg_data_i[30:0];
        scf_pkg::REG_DAMP_LINEAR:  cfg_q.damp_linear  <= cfg_data_i[30:0];
        scf_pkg::REG_DAMP_ANGULAR: cfg_q.damp_angular <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  logic [scf_pkg::NumSqrtStages:0] sq_v, sq_r;
  scf_pkg::item_t [scf_pkg::NumSqrtStages:0] sq_it;
  logic [scf_pkg::NumDivStages:0] dv_v, dv_r;
  scf_pkg::item_t [scf_pkg::NumDivStages:0] dv_it;

  scf_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (s_axis_tdata),
    .valid_o (sq_v[0]),
    .ready_i (sq_r[0]),
    .item_o  (sq_it[0])
  );

  for (genvar k = 0; k < scf_pkg::NumSqrtStages; k++) begin : g_sqrt
    scf_sqrt_stage u_sqrt (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_v[k]),
      .ready_o (sq_r[k]),
      .item_i  (sq_it[k]),
      .valid_o (sq_v[k+1]),
      .ready_i (sq_r[k+1]),
      .item_o  (sq_it[k+1])
    );
  end

  scf_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (sq_v[scf_pkg::NumSqrtStages]),
    .ready_o (sq_r[scf_pkg::NumSqrtStages]),
    .item_i  (sq_it[scf_pkg::NumSqrtStages]),
    .valid_o (dv_v[0]),
    .ready_i (dv_r[0]),
    .item_o  (dv_it[0])
  );

  for (genvar k = 0; k < scf_pkg::NumDivStages; k++) begin : g_div
    scf_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_v[k]),
      .ready_o (dv_r[k]),
      .item_i  (dv_it[k]),
      .valid_o (dv_v[k+1]),
      .ready_i (dv_r[k+1]),
      .item_o  (dv_it[k+1])
    );
  end

  scf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv_v[scf_pkg::NumDivStages]),
    .ready_o (dv_r[scf_pkg::NumDivStages]),
    .item_i  (dv_it[scf_pkg::NumDivStages]),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata),
    .user_o  (m_axis_tuser)
  );

`ifndef ASSERT_OFF
  a_no_contact_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
    else $error("nonzero output outside sphere");

  a_clip_needs_contact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("clip flag without contact");

  a_stall_front_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> sq_v[0] && !sq_r[0])
    else $error("input stalled with free front stage");
`endif

endmodule
`default_nettype wire
